FILE: rtl/uvp_pkg.sv
package uvp_pkg;

    // Field widths of the channels and the register.
    localparam int COMP_W  = 32;
    localparam int ANG_W   = 25;
    localparam int MAG_W   = 32;
    localparam int SCALE_W = 16;

    // CORDIC iteration count and datapath widths.
    localparam int CORDIC_STAGES = 20;
    localparam int SHIFT_W       = 5;
    localparam int XW            = 43;
    localparam int ZW            = 35;
    localparam int UX_W          = XW - 1;

    // Pipeline shape: one input stage, the iterations, then the finishing stages.
    localparam int FIN_STAGES  = 5;
    localparam int PIPE_STAGES = CORDIC_STAGES + 1 + FIN_STAGES;

    localparam logic [SCALE_W-1:0]      SCALE_RESET  = 16'd256;
    localparam logic signed [ZW-1:0]    DEG180_Q24   = 35'sd3019898880;
    localparam logic signed [ANG_W-1:0] DEG180_Q16   = 25'sd11796480;
    localparam logic [ANG_W:0]          DEG360_Q16   = 26'd23592960;
    localparam logic [31:0]             INV_GAIN_Q32 = 32'd2608131496;

    // atan(2^-i) in degrees, Q.24.
    localparam logic signed [ZW-1:0] ATAN_DEG_Q24 [32] = '{
        35'sd754974720, 35'sd445687602, 35'sd235489088, 35'sd119537938,
        35'sd60000934,  35'sd30029717,  35'sd15018523,  35'sd7509720,
        35'sd3754917,   35'sd1877466,   35'sd938734,    35'sd469367,
        35'sd234684,    35'sd117342,    35'sd58671,     35'sd29335,
        35'sd14668,     35'sd7334,      35'sd3667,      35'sd1833,
        35'sd917,       35'sd458,       35'sd229,       35'sd115,
        35'sd57,        35'sd29,        35'sd14,        35'sd7,
        35'sd4,         35'sd2,         35'sd1,         35'sd0
    };

    // State carried through the CORDIC iterations.
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 is_null;
    } cordic_t;

    // Finished result as it leaves the block.
    typedef struct packed {
        logic signed [ANG_W-1:0] angle_deg;
        logic [ANG_W-1:0]        opposite_angle_deg;
        logic [MAG_W-1:0]        magnitude;
        logic [MAG_W-1:0]        half_magnitude;
        logic                    is_null;
    } polar_t;

endpackage

FILE: rtl/uvp_in_if.sv
interface uvp_in_if;

    logic                              valid;
    logic                              ready;
    logic signed [uvp_pkg::COMP_W-1:0] u_comp;
    logic signed [uvp_pkg::COMP_W-1:0] v_comp;

    modport source (output valid, output u_comp, output v_comp, input ready);
    modport sink   (input valid, input u_comp, input v_comp, output ready);

endinterface

FILE: rtl/uvp_out_if.sv
interface uvp_out_if;

    logic                             valid;
    logic                             ready;
    logic signed [uvp_pkg::ANG_W-1:0] angle_deg;
    logic [uvp_pkg::ANG_W-1:0]        opposite_angle_deg;
    logic [uvp_pkg::MAG_W-1:0]        magnitude;
    logic [uvp_pkg::MAG_W-1:0]        half_magnitude;
    logic                             is_null;

    modport source (output valid, output angle_deg, output opposite_angle_deg,
                    output magnitude, output half_magnitude, output is_null,
                    input ready);
    modport sink   (input valid, input angle_deg, input opposite_angle_deg,
                    input magnitude, input half_magnitude, input is_null,
                    output ready);

endinterface

FILE: rtl/uvp_cordic_stage.sv
module uvp_cordic_stage (
    input  logic                               clk,
    input  logic                               en,
    input  logic [uvp_pkg::SHIFT_W-1:0]        shift,
    input  logic signed [uvp_pkg::ZW-1:0]      atan_step,
    input  uvp_pkg::cordic_t                   d,
    output uvp_pkg::cordic_t                   q
);

    logic signed [uvp_pkg::XW-1:0] x_in;
    logic signed [uvp_pkg::XW-1:0] y_in;
    logic signed [uvp_pkg::XW-1:0] xs;
    logic signed [uvp_pkg::XW-1:0] ys;
    uvp_pkg::cordic_t              stage_next;
    uvp_pkg::cordic_t              stage_reg;

    // One vectoring micro-rotation: drive y towards zero, both updates from the old x and y.
    always_comb
    begin
        x_in = d.x;
        y_in = d.y;
        xs   = x_in >>> shift;
        ys   = y_in >>> shift;
        stage_next.is_null = d.is_null;
        if (!y_in[uvp_pkg::XW-1])
        begin
            stage_next.x = x_in + ys;
            stage_next.y = y_in - xs;
            stage_next.z = d.z + atan_step;
        end
        else
        begin
            stage_next.x = x_in - ys;
            stage_next.y = y_in + xs;
            stage_next.z = d.z - atan_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign q = stage_reg;

endmodule

FILE: rtl/uvp_finish.sv
module uvp_finish (
    input  logic                              clk,
    input  logic [uvp_pkg::FIN_STAGES-1:0]    en,
    input  logic [uvp_pkg::SCALE_W-1:0]       length_scale,
    input  uvp_pkg::cordic_t                  d,
    output uvp_pkg::polar_t                   q
);

    // First stage: round and clamp the angle, keep the non-negative length.
    logic signed [uvp_pkg::ZW-1:0]    z_round;
    logic signed [uvp_pkg::ANG_W-1:0] ang1_next;
    logic [uvp_pkg::UX_W-1:0]         ux1_next;
    logic signed [uvp_pkg::ANG_W-1:0] ang1_reg;
    logic [uvp_pkg::UX_W-1:0]         ux1_reg;
    logic                             null1_reg;

    always_comb
    begin
        z_round = (d.z + uvp_pkg::ZW'(128)) >>> 8;
        if (d.is_null)
        begin
            ang1_next = '0;
        end
        else if (z_round > uvp_pkg::ZW'(uvp_pkg::DEG180_Q16))
        begin
            ang1_next = uvp_pkg::DEG180_Q16;
        end
        else if (z_round < -uvp_pkg::ZW'(uvp_pkg::DEG180_Q16))
        begin
            ang1_next = -uvp_pkg::DEG180_Q16;
        end
        else
        begin
            ang1_next = z_round[uvp_pkg::ANG_W-1:0];
        end
        if (d.x > 0)
        begin
            ux1_next = d.x[uvp_pkg::UX_W-1:0];
        end
        else
        begin
            ux1_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ang1_reg  <= ang1_next;
            ux1_reg   <= ux1_next;
            null1_reg <= d.is_null;
        end
    end

    // Second stage: opposite direction and the two gain partial products.
    logic [uvp_pkg::ANG_W:0]          opp_sum;
    logic [uvp_pkg::ANG_W-1:0]        opp2_next;
    logic [63:0]                      plo2_next;
    logic [41:0]                      phi2_next;
    logic signed [uvp_pkg::ANG_W-1:0] ang2_reg;
    logic [uvp_pkg::ANG_W-1:0]        opp2_reg;
    logic [63:0]                      plo2_reg;
    logic [41:0]                      phi2_reg;
    logic                             null2_reg;

    always_comb
    begin
        opp_sum = (uvp_pkg::ANG_W + 1)'(signed'({ang1_reg[uvp_pkg::ANG_W-1], ang1_reg})
                  + (uvp_pkg::ANG_W + 1)'(uvp_pkg::DEG180_Q16));
        if (opp_sum >= uvp_pkg::DEG360_Q16)
        begin
            opp_sum = opp_sum - uvp_pkg::DEG360_Q16;
        end
        opp2_next = opp_sum[uvp_pkg::ANG_W-1:0];
        plo2_next = 64'(ux1_reg[31:0]) * 64'(uvp_pkg::INV_GAIN_Q32);
        phi2_next = 42'(ux1_reg[uvp_pkg::UX_W-1:32]) * 42'(uvp_pkg::INV_GAIN_Q32);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ang2_reg  <= ang1_reg;
            opp2_reg  <= opp2_next;
            plo2_reg  <= plo2_next;
            phi2_reg  <= phi2_next;
            null2_reg <= null1_reg;
        end
    end

    // Third stage: gain-compensated length.
    logic [42:0]                      r3_next;
    logic signed [uvp_pkg::ANG_W-1:0] ang3_reg;
    logic [uvp_pkg::ANG_W-1:0]        opp3_reg;
    logic [42:0]                      r3_reg;
    logic                             null3_reg;

    assign r3_next = 43'(phi2_reg) + 43'(plo2_reg[63:32]);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            ang3_reg  <= ang2_reg;
            opp3_reg  <= opp2_reg;
            r3_reg    <= r3_next;
            null3_reg <= null2_reg;
        end
    end

    // Fourth stage: scale the length in two halves.
    logic [39:0]                      mlo4_next;
    logic [34:0]                      mhi4_next;
    logic signed [uvp_pkg::ANG_W-1:0] ang4_reg;
    logic [uvp_pkg::ANG_W-1:0]        opp4_reg;
    logic [39:0]                      mlo4_reg;
    logic [34:0]                      mhi4_reg;
    logic                             null4_reg;

    assign mlo4_next = 40'(r3_reg[23:0]) * 40'(length_scale);
    assign mhi4_next = 35'(r3_reg[42:24]) * 35'(length_scale);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            ang4_reg  <= ang3_reg;
            opp4_reg  <= opp3_reg;
            mlo4_reg  <= mlo4_next;
            mhi4_reg  <= mhi4_next;
            null4_reg <= null3_reg;
        end
    end

    // Fifth stage: round, halve and saturate into the output register.
    logic [59:0]     m_full;
    logic [59:0]     mag_full;
    logic [59:0]     half_full;
    uvp_pkg::polar_t res_next;
    uvp_pkg::polar_t res_reg;

    always_comb
    begin
        m_full    = (60'(mhi4_reg) << 24) + 60'(mlo4_reg);
        mag_full  = (m_full + 60'(32768)) >> 16;
        half_full = (m_full + 60'(65536)) >> 17;
        res_next.angle_deg          = ang4_reg;
        res_next.opposite_angle_deg = opp4_reg;
        res_next.is_null            = null4_reg;
        if (|mag_full[59:uvp_pkg::MAG_W])
        begin
            res_next.magnitude = '1;
        end
        else
        begin
            res_next.magnitude = mag_full[uvp_pkg::MAG_W-1:0];
        end
        if (|half_full[59:uvp_pkg::MAG_W])
        begin
            res_next.half_magnitude = '1;
        end
        else
        begin
            res_next.half_magnitude = half_full[uvp_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            res_reg <= res_next;
        end
    end

    assign q = res_reg;

endmodule

FILE: rtl/uv_vector_to_polar_core.sv
// Converts a stream of (u, v) vectors in signed Q16.16 to polar form: direction in degrees
// (-180 to 180), the opposite direction (0 to below 360), the scaled length and half of
// it, with a flag for the null vector. One vector is taken in every clock cycle while the
// input ready is high; a stall on the output can hold it low. There are 26 register stages:
// one input stage that folds the vector into the right half-plane, one stage for each of
// the 20 CORDIC iterations, and five stages for rounding, gain compensation, scaling and
// saturation. Every stage holds its own valid bit, so a stall on the output halts only the
// unbroken run of full stages at the output end; the stages before the first empty stage
// keep moving and taking transfers. The length scale register is unsigned Q8.8 and resets
// to 1.0; write it only while the pipeline is empty.
module uv_vector_to_polar_core (
    input  logic                           clk,
    input  logic                           rst_n,
    uvp_in_if.sink                         vec,
    uvp_out_if.source                      polar,
    input  logic                           cfg_we,
    input  logic [uvp_pkg::SCALE_W-1:0]    cfg_wdata
);

    logic [uvp_pkg::SCALE_W-1:0]     length_scale_reg;
    logic [uvp_pkg::PIPE_STAGES-1:0] vld_reg;
    logic [uvp_pkg::PIPE_STAGES-1:0] vld_next;
    logic [uvp_pkg::PIPE_STAGES:0]   adv;
    uvp_pkg::cordic_t                stg [uvp_pkg::CORDIC_STAGES+1];
    uvp_pkg::cordic_t                pre_next;
    uvp_pkg::cordic_t                pre_reg;
    uvp_pkg::polar_t                 res;
    logic signed [uvp_pkg::COMP_W+7:0] u_sh;
    logic signed [uvp_pkg::COMP_W+7:0] v_sh;

    // Length scale register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_scale_reg <= uvp_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            length_scale_reg <= cfg_wdata;
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        adv[uvp_pkg::PIPE_STAGES] = polar.ready;
        for (int k = uvp_pkg::PIPE_STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        if (adv[0])
        begin
            vld_next[0] = vec.valid;
        end
        else
        begin
            vld_next[0] = vld_reg[0];
        end
        for (int k = 1; k < uvp_pkg::PIPE_STAGES; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
            else
            begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign vec.ready = adv[0];

    // Input stage: scale to Q.24 and fold a vector with negative u into the right half-plane.
    always_comb
    begin
        u_sh = {vec.u_comp, 8'b0};
        v_sh = {vec.v_comp, 8'b0};
        pre_next.is_null = (vec.u_comp == '0) && (vec.v_comp == '0);
        if (vec.u_comp[uvp_pkg::COMP_W-1])
        begin
            pre_next.x = -uvp_pkg::XW'(u_sh);
            pre_next.y = -uvp_pkg::XW'(v_sh);
            if (!vec.v_comp[uvp_pkg::COMP_W-1])
            begin
                pre_next.z = uvp_pkg::DEG180_Q24;
            end
            else
            begin
                pre_next.z = -uvp_pkg::DEG180_Q24;
            end
        end
        else
        begin
            pre_next.x = uvp_pkg::XW'(u_sh);
            pre_next.y = uvp_pkg::XW'(v_sh);
            pre_next.z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pre_reg <= pre_next;
        end
    end

    assign stg[0] = pre_reg;

    // CORDIC iterations, one register stage each.
    for (genvar i = 0; i < uvp_pkg::CORDIC_STAGES; i++)
    begin : g_iter
        uvp_cordic_stage u_stage (
            .clk       (clk),
            .en        (adv[i+1]),
            .shift     (uvp_pkg::SHIFT_W'(i)),
            .atan_step (uvp_pkg::ATAN_DEG_Q24[i]),
            .d         (stg[i]),
            .q         (stg[i+1])
        );
    end

    // Rounding, gain compensation, scaling and the output register.
    uvp_finish u_finish (
        .clk          (clk),
        .en           (adv[uvp_pkg::CORDIC_STAGES+1 +: uvp_pkg::FIN_STAGES]),
        .length_scale (length_scale_reg),
        .d            (stg[uvp_pkg::CORDIC_STAGES]),
        .q            (res)
    );

    assign polar.valid              = vld_reg[uvp_pkg::PIPE_STAGES-1];
    assign polar.angle_deg          = res.angle_deg;
    assign polar.opposite_angle_deg = res.opposite_angle_deg;
    assign polar.magnitude          = res.magnitude;
    assign polar.half_magnitude     = res.half_magnitude;
    assign polar.is_null            = res.is_null;

endmodule

FILE: rtl/uvp_checker.sv
module uvp_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic signed [uvp_pkg::ANG_W-1:0] angle_deg,
    input  logic [uvp_pkg::ANG_W-1:0]        opposite_angle_deg,
    input  logic [uvp_pkg::MAG_W-1:0]        magnitude,
    input  logic [uvp_pkg::MAG_W-1:0]        half_magnitude,
    input  logic                             is_null
);

    logic [uvp_pkg::ANG_W:0] opp_expect;

    // Opposite direction as it must follow from the direction shown.
    always_comb
    begin
        if (angle_deg == uvp_pkg::DEG180_Q16)
        begin
            opp_expect = '0;
        end
        else
        begin
            opp_expect = (uvp_pkg::ANG_W + 1)'(signed'({angle_deg[uvp_pkg::ANG_W-1], angle_deg})
                         + (uvp_pkg::ANG_W + 1)'(uvp_pkg::DEG180_Q16));
        end
    end

    // A stalled result holds its direction, length and null flag until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(angle_deg)
            && $stable(magnitude) && $stable(is_null))
        else $error("uvp: stalled result changed");

    // The direction never leaves the half-turn range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angle_deg <= uvp_pkg::DEG180_Q16 && angle_deg >= -uvp_pkg::DEG180_Q16)
        else $error("uvp: direction out of range");

    // The opposite direction agrees with the direction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> opposite_angle_deg == opp_expect[uvp_pkg::ANG_W-1:0])
        else $error("uvp: opposite direction inconsistent");

    // A null vector has no length and no direction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_null |-> magnitude == '0 && half_magnitude == '0 && angle_deg == '0)
        else $error("uvp: null vector result not zero");

    // Half the length never exceeds the length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> half_magnitude <= magnitude)
        else $error("uvp: half length above length");

endmodule

bind uv_vector_to_polar_core uvp_checker u_uvp_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (polar.valid),
    .out_ready          (polar.ready),
    .angle_deg          (polar.angle_deg),
    .opposite_angle_deg (polar.opposite_angle_deg),
    .magnitude          (polar.magnitude),
    .half_magnitude     (polar.half_magnitude),
    .is_null            (polar.is_null)
);

FILE: test/uv_vector_to_polar_core_test.sv
module uv_vector_to_polar_core_test;

    typedef uvp_pkg::polar_t polar_t;

    // One vector waiting to be sent.
    typedef struct packed {
        logic signed [uvp_pkg::COMP_W-1:0] u;
        logic signed [uvp_pkg::COMP_W-1:0] v;
    } vector_t;

    localparam longint    HALF_TURN_Q24 = 64'sd3019898880;
    localparam longint    HALF_TURN_Q16 = 64'sd11796480;
    localparam longint    FULL_TURN_Q16 = 64'sd23592960;
    localparam bit [63:0] INV_GAIN_Q32  = 64'd2608131496;
    localparam bit [63:0] LENGTH_MAX    = 64'hFFFF_FFFF;
    localparam int        PHASE_COUNT   = 9;
    localparam int        PHASE_ITEMS   = 184;
    localparam int        DRAIN_CYCLES  = 40;
    localparam int        LIMIT_CYCLES  = 1000000;

    localparam logic signed [31:0] COMP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COMP_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE_Q16  = 32'sh0001_0000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    uvp_in_if  vec_if ();
    uvp_out_if polar_if ();

    uv_vector_to_polar_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vec       (vec_if),
        .polar     (polar_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    vector_t     pending_q [$];
    polar_t      polar_due_q [$];
    polar_t      want_polar;
    logic [15:0] scale_model = 16'd256;
    bit          idle_enable = 1'b1;
    int unsigned send_gap;
    int unsigned stall_left;
    int          error_count = 0;
    int          vectors_sent = 0;
    int          results_checked = 0;
    int          settings_used = 1;
    int          cycle_count = 0;

    // Clock with a period of 8.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Arctangent of 2^-i in degrees, Q.24.
    function automatic longint atan_q24(input int idx);
        case (idx)
            0: return 754974720;   1: return 445687602;  2: return 235489088;
            3: return 119537938;   4: return 60000934;   5: return 30029717;
            6: return 15018523;    7: return 7509720;    8: return 3754917;
            9: return 1877466;     10: return 938734;    11: return 469367;
            12: return 234684;     13: return 117342;    14: return 58671;
            15: return 29335;      16: return 14668;     17: return 7334;
            18: return 3667;       19: return 1833;      20: return 917;
            21: return 458;        22: return 229;       23: return 115;
            24: return 57;         25: return 29;        26: return 14;
            27: return 7;          28: return 4;         29: return 2;
            30: return 1;
            default: return 0;
        endcase
    endfunction

    // Polar form of one vector at the given length scale.
    function automatic polar_t predict_polar(input logic signed [31:0] u,
                                             input logic signed [31:0] v,
                                             input logic [15:0] scale);
        polar_t    res;
        longint    x;
        longint    y;
        longint    z;
        longint    xs;
        longint    ys;
        longint    ang;
        longint    opp;
        bit [63:0] ux;
        bit [63:0] r;
        bit [63:0] m;
        bit [63:0] mag;
        bit [63:0] half;
        res = '0;
        // The null vector has a fixed answer.
        if (u == 0 && v == 0)
        begin
            res.opposite_angle_deg = HALF_TURN_Q16[24:0];
            res.is_null = 1'b1;
            return res;
        end
        // Fold the left half-plane over and start from a half turn.
        x = longint'(u) * 256;
        y = longint'(v) * 256;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = (v >= 0) ? HALF_TURN_Q24 : -HALF_TURN_Q24;
        end
        // Vectoring iterations drive y towards zero.
        for (int i = 0; i < uvp_pkg::CORDIC_STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q24(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q24(i);
            end
        end
        // Round the angle to Q.16, clamp it and form the opposite direction.
        ang = (z + 128) >>> 8;
        if (ang > HALF_TURN_Q16)
            ang = HALF_TURN_Q16;
        if (ang < -HALF_TURN_Q16)
            ang = -HALF_TURN_Q16;
        opp = ang + HALF_TURN_Q16;
        if (opp >= FULL_TURN_Q16)
            opp = opp - FULL_TURN_Q16;
        // Remove the CORDIC gain, apply the scale, round and saturate.
        ux = (x > 0) ? x : 0;
        r = (ux >> 32) * INV_GAIN_Q32 + (((ux & 64'hFFFF_FFFF) * INV_GAIN_Q32) >> 32);
        m = r * {48'd0, scale};
        mag = (m + 64'd32768) >> 16;
        half = (m + 64'd65536) >> 17;
        if (mag > LENGTH_MAX)
            mag = LENGTH_MAX;
        if (half > LENGTH_MAX)
            half = LENGTH_MAX;
        res.angle_deg = ang[24:0];
        res.opposite_angle_deg = opp[24:0];
        res.magnitude = mag[31:0];
        res.half_magnitude = half[31:0];
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(3, 1);
        if (p < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // A component taken from the corners of the range.
    function automatic logic signed [31:0] extreme_comp();
        case ($urandom_range(6))
            0: return COMP_MAX;
            1: return COMP_MIN;
            2: return 32'sd0;
            3: return 32'sd1;
            4: return -32'sd1;
            5: return ONE_Q16;
            default: return -ONE_Q16;
        endcase
    endfunction

    // Random vector drawn from a mix of shapes.
    function automatic vector_t random_vector();
        vector_t     vec;
        int unsigned pick;
        logic [31:0] raw;
        pick = $urandom_range(99);
        raw = $urandom;
        if (pick < 35)
        begin
            vec.u = $urandom;
            vec.v = $urandom;
        end
        else if (pick < 65)
        begin
            // Both components of moderate size, so lengths do not always saturate.
            vec.u = $signed(raw) >>> $urandom_range(31, 4);
            raw = $urandom;
            vec.v = $signed(raw) >>> $urandom_range(31, 4);
        end
        else if (pick < 80)
        begin
            // Close to an axis, which reaches the half-turn clamp on the left.
            vec.u = $signed(raw) >>> $urandom_range(20, 0);
            vec.v = $signed({30'd0, 2'($urandom_range(2))}) - 32'sd1;
            if ($urandom_range(1) == 1)
                vec = '{u: vec.v, v: vec.u};
        end
        else if (pick < 92)
        begin
            vec.u = extreme_comp();
            vec.v = extreme_comp();
        end
        else if (pick < 95)
        begin
            vec.u = 32'sd0;
            vec.v = 32'sd0;
        end
        else
        begin
            // Diagonals.
            vec.u = $signed(raw) >>> $urandom_range(24, 1);
            vec.v = ($urandom_range(1) == 1) ? vec.u : -vec.u;
        end
        return vec;
    endfunction

    task automatic push_vector(input logic signed [31:0] u, input logic signed [31:0] v);
        pending_q.push_back('{u: u, v: v});
    endtask

    // Waits until every vector has been sent and every result has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || vec_if.valid || polar_due_q.size() != 0);
    endtask

    task automatic write_scale(input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        scale_model = value;
        settings_used++;
    endtask

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Sender: presents the next pending vector once the previous transfer is done.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_if.valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!vec_if.valid || vec_if.ready)
        begin
            if (send_gap != 0)
            begin
                vec_if.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_q.size() != 0)
            begin
                vec_if.valid <= 1'b1;
                vec_if.u_comp <= pending_q[0].u;
                vec_if.v_comp <= pending_q[0].v;
                void'(pending_q.pop_front());
                send_gap <= idle_enable ? pick_gap() : 0;
            end
            else
            begin
                vec_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls on the result side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polar_if.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            polar_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            polar_if.ready <= 1'b1;
            if (idle_enable && $urandom_range(7) == 0)
                stall_left <= pick_gap();
        end
    end

    // Monitor: predicts on each input transfer and checks each result transfer.
    always @(posedge clk)
    begin
        if (rst_n && vec_if.valid && vec_if.ready)
        begin
            polar_due_q.push_back(predict_polar(vec_if.u_comp, vec_if.v_comp, scale_model));
            vectors_sent++;
        end
        if (rst_n && polar_if.valid && polar_if.ready)
        begin
            if (polar_due_q.size() == 0)
            begin
                $display("%0t: result transfer with no result due", $time);
                error_count++;
            end
            else
            begin
                want_polar = polar_due_q.pop_front();
                check_field("angle_deg", want_polar.angle_deg, polar_if.angle_deg);
                check_field("opposite_angle_deg", want_polar.opposite_angle_deg,
                            polar_if.opposite_angle_deg);
                check_field("magnitude", want_polar.magnitude, polar_if.magnitude);
                check_field("half_magnitude", want_polar.half_magnitude,
                            polar_if.half_magnitude);
                check_field("is_null", want_polar.is_null, polar_if.is_null);
                results_checked++;
            end
        end
    end

    // Watchdog on the length of the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("%0t: run stopped by the cycle limit", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus sequence: reset, directed vectors, then random phases per scale.
    initial
    begin
        logic [15:0] next_scale;
        vec_if.valid = 1'b0;
        vec_if.u_comp = '0;
        vec_if.v_comp = '0;
        polar_if.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed vectors at the reset scale: axes, corners, diagonals and the
        // vectors that sit right on the half turn.
        push_vector(32'sd0, 32'sd0);
        push_vector(32'sd1, 32'sd0);
        push_vector(32'sd0, 32'sd1);
        push_vector(-32'sd1, 32'sd0);
        push_vector(32'sd0, -32'sd1);
        push_vector(COMP_MAX, 32'sd0);
        push_vector(COMP_MIN, 32'sd0);
        push_vector(32'sd0, COMP_MAX);
        push_vector(32'sd0, COMP_MIN);
        push_vector(COMP_MAX, COMP_MAX);
        push_vector(COMP_MIN, COMP_MIN);
        push_vector(COMP_MIN, COMP_MAX);
        push_vector(COMP_MAX, COMP_MIN);
        push_vector(ONE_Q16, ONE_Q16);
        push_vector(-ONE_Q16, ONE_Q16);
        push_vector(-ONE_Q16, -ONE_Q16);
        push_vector(ONE_Q16, -ONE_Q16);
        push_vector(-ONE_Q16, 32'sd0);
        push_vector(-ONE_Q16, 32'sd1);
        push_vector(-ONE_Q16, -32'sd1);
        push_vector(COMP_MIN, 32'sd1);
        push_vector(COMP_MAX, 32'sd1);
        wait_drained();

        // Random phases; each one starts from an empty pipeline.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: next_scale = 16'hFFFF;
                1: next_scale = 16'h0000;
                2: next_scale = 16'd256;
                3: next_scale = 16'd1;
                default: next_scale = 16'($urandom_range(65535));
            endcase
            idle_enable = (phase % 3) != 2;
            write_scale(next_scale);
            @(negedge clk);
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_q.push_back(random_vector());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d vectors and checked %0d results over %0d length scale settings,",
                 vectors_sent, results_checked, settings_used);
        $display("covering null vectors, range corners, half-turn clamps and saturated lengths.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
rtl/uvp_pkg.sv
rtl/uvp_in_if.sv
rtl/uvp_out_if.sv
rtl/uvp_cordic_stage.sv
rtl/uvp_finish.sv
rtl/uv_vector_to_polar_core.sv
rtl/uvp_checker.sv
test/uv_vector_to_polar_core_test.sv
